### sv/bspo_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and tables for the band-limited saw/pulse oscillator.
package bspo_pkg;

	// Sequencer states: one per shared-unit operation, plus idle, sinc setup and finish
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_NOTE_DIV,
		ST_Y_MUL,
		ST_EXP_MUL,
		ST_EXP_DIV,
		ST_RATE_DIV,
		ST_HALF_MUL,
		ST_PW_MUL,
		ST_MOD_PULSE,
		ST_MOD_PHASE,
		ST_DC_DIV,
		ST_DC_MUL,
		ST_LEAK_MUL,
		ST_SINC_SETUP,
		ST_SIN_ARG,
		ST_SIN_SQ1,
		ST_SIN_SQ2,
		ST_SIN_DIV,
		ST_DEN_MUL,
		ST_SINC_DIV,
		ST_MIX_MUL,
		ST_FINISH
	} st_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_SAMPLE_RATE  = 2'd0,
		REG_WAVEFORM_MIX = 2'd1,
		REG_PULSE_WIDTH  = 2'd2
	} cfg_reg_t;

	localparam logic [17:0] SAMPLE_RATE_RST = 18'd44100;
	localparam logic [15:0] MIX_RST         = 16'd0;
	localparam logic [15:0] PW_RST          = 16'd32768;

	// Note range and pitch-to-period constants
	localparam logic signed [16:0] NOTE_MIN = -17'sd16384;
	localparam logic signed [16:0] NOTE_MAX = 17'sd49151;
	localparam logic signed [17:0] M_OFFSET = 18'sd54528;
	localparam logic [11:0] SEMI_DIV  = 12'd3072;
	localparam logic [4:0]  OCT_BIAS  = 5'd12;
	localparam logic [17:0] LN2_3072  = 18'd242272;
	localparam logic [9:0]  RATE_DIV  = 10'd880;
	localparam logic [3:0]  EXP_TERMS = 4'd12;
	localparam logic [2:0]  SIN_TERMS = 3'd7;

	// Q30 and Q16 constants
	localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
	localparam logic [29:0] Q30_HALF  = 30'h2000_0000;
	localparam logic [31:0] PI_Q30    = 32'd3373259426;
	localparam logic [14:0] DC_Q16    = 15'd32637;
	localparam logic [15:0] LEAK_Q16  = 16'd65405;
	localparam logic [16:0] SINC_ONE  = 17'd65536;

	// Divisor of the k-th sine series term: (2k)(2k+1)
	function automatic logic [7:0] sin_div(input logic [2:0] k);
		logic [7:0] d;
		case (k)
			3'd1:    d = 8'd6;
			3'd2:    d = 8'd20;
			3'd3:    d = 8'd42;
			3'd4:    d = 8'd72;
			3'd5:    d = 8'd110;
			3'd6:    d = 8'd156;
			3'd7:    d = 8'd210;
			default: d = 8'd1;
		endcase
		return d;
	endfunction

endpackage

### sv/bspo_mul.sv
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module bspo_mul #(
	parameter int unsigned MA = 32,
	parameter int unsigned MB = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MA-1:0]      a,
	input  logic [MB-1:0]      b,
	output logic               done,
	output logic [MA+MB-1:0]   product
);

	localparam int unsigned CW = $clog2(MB + 1);

	logic [MA+MB-1:0] prod_q;
	logic [MA-1:0]    a_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [MA:0]      sum;

	// Add the multiplicand when the low multiplier bit is set
	assign sum = {1'b0, prod_q[MA+MB-1:MB]} + (prod_q[0] ? {1'b0, a_q} : {(MA+1){1'b0}});

	// Count steps and flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(MB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the partial product right one bit a step
	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{MA{1'b0}}, b};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[MB-1:1]};
		end
	end

	assign done    = done_q;
	assign product = prod_q;

endmodule

### sv/bspo_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
module bspo_div #(
	parameter int unsigned ND = 47,
	parameter int unsigned DV = 34
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [ND-1:0] dividend,
	input  logic [DV-1:0] divisor,
	output logic          done,
	output logic [ND-1:0] quotient,
	output logic [DV-1:0] remainder
);

	localparam int unsigned CW = $clog2(ND + 1);

	logic [ND-1:0] quo_q;
	logic [DV-1:0] rem_q;
	logic [DV-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DV:0]   trial;
	logic [DV:0]   diff;
	logic          fits;

	// Bring down the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[ND-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	// Count steps and flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(ND);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift quotient bits in, keep the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DV-1:0] : trial[DV-1:0];
			quo_q <= {quo_q[ND-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### sv/blit_saw_pulse_oscillator_core.sv
`timescale 1ns / 1ps
// Top level: band-limited sawtooth/pulse oscillator with a serial sequencer.
//
// Channel   Dir  Handshake              Payload
// pitch     in   pitch_valid/stall      pitch_note  (signed Q8.8 semitones)
// sample    out  sample_valid/stall     sample_out  (signed Q15.16)
// cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// The length of one pitch beat is set by the bit-serial multiplier (32 steps) and divider
// (PHASE_FRAC_BITS+31 steps) that the sequencer shares over every operation.
// Reset clears phase and integrator and loads the register defaults; no sweep follows.
// A new pitch beat is taken while a finished sample still waits on sample_stall.
// cfg_ready is always high.
module blit_saw_pulse_oscillator_core
	import bspo_pkg::*;
#(
	parameter int unsigned PHASE_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pitch_valid,
	output logic               pitch_stall,
	input  logic signed [16:0] pitch_note,
	output logic               sample_valid,
	input  logic               sample_stall,
	output logic signed [31:0] sample_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int unsigned F  = PHASE_FRAC_BITS;
	localparam int unsigned ND = F + 31;
	localparam int unsigned DV = 34;
	localparam int unsigned MA = (F + 15 > 32) ? F + 15 : 32;
	localparam int unsigned MB = 32;
	localparam int unsigned PW = MA + MB;
	localparam int unsigned AW = MA + 2;
	localparam int unsigned HW = F + 22;
	localparam logic signed [AW-1:0] SAT_HI = AW'(2147483647);
	localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

	// Sequencer and configuration
	st_t state_q, state_d;
	logic        issued_q;
	logic [17:0] sr_q;
	logic [15:0] mix_q;
	logic [15:0] pw_q;
	logic [31:0] phase_q;
	logic signed [31:0] integ_q;
	logic        valid_q;

	// Working registers
	logic signed [16:0] note_q;
	logic signed [4:0]  k_q;
	logic [11:0]        r_q;
	logic [29:0]        y_q;
	logic [30:0]        term_q;
	logic [31:0]        t_q;
	logic [31:0]        esum_q;
	logic [3:0]         i_q;
	logic [F+8:0]       a_q;
	logic [30:0]        h_q;
	logic [31:0]        off_q;
	logic [31:0]        p2_q;
	logic [F+14:0]      dc_q;
	logic signed [AW-1:0] acc_q;
	logic               sel_q;
	logic [31:0]        ax_q;
	logic               neg_q;
	logic [29:0]        w30_q;
	logic [30:0]        sa_q;
	logic signed [33:0] ssum_q;
	logic [2:0]         kk_q;
	logic [32:0]        den_q;
	logic [24:0]        smag_q;

	// Shared units
	logic          mul_start, mul_done;
	logic [MA-1:0] mul_a;
	logic [MB-1:0] mul_b;
	logic [PW-1:0] prod;
	logic          div_start, div_done;
	logic [ND-1:0] div_n, quo;
	logic [DV-1:0] div_d, rem;
	logic          is_mul, is_div, op_done;

	// Derived values
	logic signed [16:0] note_c;
	logic signed [17:0] m_wide;
	logic [31:0]        per;
	logic [F+10:0]      hraw;
	logic [HW-1:0]      hs, h_sh;
	logic [30:0]        h_new;
	logic signed [32:0] x1, x2, xs, ax_s;
	logic [F:0]         u;
	logic [29:0]        w30_raw, w30;
	logic [30:0]        s_cl;
	logic [32:0]        den_new;
	logic [23:0]        q24;
	logic [31:0]        integ_mag;
	logic signed [AW-1:0] p16;
	logic signed [AW-1:0] q_ext;
	logic signed [AW-1:0] acc_sat_src;
	logic signed [31:0] sat_val;
	logic               accept;
	logic               out_free;

	assign accept   = pitch_valid && !pitch_stall;
	assign out_free = !valid_q || !sample_stall;

	bspo_mul #(.MA(MA), .MB(MB)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .product(prod)
	);

	bspo_div #(.ND(ND), .DV(DV)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_n), .divisor(div_d),
		.done(div_done), .quotient(quo), .remainder(rem)
	);

	// Clamp the note and form the semitone offset
	always_comb begin
		if (note_q < NOTE_MIN) begin
			note_c = NOTE_MIN;
		end else if (note_q > NOTE_MAX) begin
			note_c = NOTE_MAX;
		end else begin
			note_c = note_q;
		end
		m_wide = M_OFFSET - 18'(note_c);
	end

	// Half period from the rate product and the octave shift
	always_comb begin
		hraw = prod[F+34:24];
		hs   = HW'(hraw);
		if (k_q[4]) begin
			h_sh = hs >> 4'(-k_q);
		end else begin
			h_sh = hs << k_q[3:0];
		end
		if (h_sh > HW'(32'h7FFF_FFFF)) begin
			h_new = 31'h7FFF_FFFF;
		end else if (h_sh == '0) begin
			h_new = 31'd1;
		end else begin
			h_new = h_sh[30:0];
		end
	end

	assign per = {h_q, 1'b0};

	// Fold the pulse argument into the first half of a sine period
	always_comb begin
		x1   = $signed({1'b0, phase_q}) - $signed({2'b00, h_q});
		x2   = $signed({1'b0, p2_q}) - $signed({2'b00, h_q});
		xs   = sel_q ? x2 : x1;
		ax_s = xs[32] ? -xs : xs;
		u    = ax_s[F:0];
		w30_raw = 30'(u[F-1:0]) << (30 - F);
		if (w30_raw > Q30_HALF) begin
			w30 = 30'(Q30_ONE - 31'(w30_raw));
		end else begin
			w30 = w30_raw;
		end
	end

	// Clamp the sine sum, take the denominator and the sinc quotient
	always_comb begin
		if (ssum_q < 0) begin
			s_cl = '0;
		end else if (ssum_q > $signed({3'b000, Q30_ONE})) begin
			s_cl = Q30_ONE;
		end else begin
			s_cl = ssum_q[30:0];
		end
		den_new = (prod[62:30] == '0) ? 33'd1 : prod[62:30];
		q24     = quo[37:14];
		q_ext   = AW'($signed({1'b0, q24}));
	end

	assign p16       = AW'($signed({1'b0, prod[PW-1:16]}));
	assign integ_mag = integ_q[31] ? 32'(-integ_q) : 32'(integ_q);

	// Saturate the integrator sum
	always_comb begin
		acc_sat_src = acc_q;
		if (acc_sat_src > SAT_HI) begin
			sat_val = 32'sh7FFF_FFFF;
		end else if (acc_sat_src < SAT_LO) begin
			sat_val = -32'sh7FFF_FFFF - 32'sd1;
		end else begin
			sat_val = acc_sat_src[31:0];
		end
	end

	// Classify the current operation
	always_comb begin
		is_mul = 1'b0;
		is_div = 1'b0;
		case (state_q) inside
			ST_Y_MUL, ST_EXP_MUL, ST_HALF_MUL, ST_PW_MUL, ST_DC_MUL, ST_LEAK_MUL,
			ST_SIN_ARG, ST_SIN_SQ1, ST_SIN_SQ2, ST_DEN_MUL, ST_MIX_MUL: is_mul = 1'b1;
			ST_NOTE_DIV, ST_EXP_DIV, ST_RATE_DIV, ST_MOD_PULSE, ST_MOD_PHASE,
			ST_DC_DIV, ST_SIN_DIV, ST_SINC_DIV: is_div = 1'b1;
			default: ;
		endcase
		op_done = (is_mul && mul_done) || (is_div && div_done);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (pitch_valid) state_d = ST_NOTE_DIV;
			ST_NOTE_DIV:   if (op_done) state_d = ST_Y_MUL;
			ST_Y_MUL:      if (op_done) state_d = ST_EXP_MUL;
			ST_EXP_MUL:    if (op_done) state_d = ST_EXP_DIV;
			ST_EXP_DIV:    if (op_done) state_d = (i_q == EXP_TERMS) ? ST_RATE_DIV : ST_EXP_MUL;
			ST_RATE_DIV:   if (op_done) state_d = ST_HALF_MUL;
			ST_HALF_MUL:   if (op_done) state_d = ST_PW_MUL;
			ST_PW_MUL:     if (op_done) state_d = ST_MOD_PULSE;
			ST_MOD_PULSE:  if (op_done) state_d = ST_MOD_PHASE;
			ST_MOD_PHASE:  if (op_done) state_d = ST_DC_DIV;
			ST_DC_DIV:     if (op_done) state_d = ST_DC_MUL;
			ST_DC_MUL:     if (op_done) state_d = ST_LEAK_MUL;
			ST_LEAK_MUL:   if (op_done) state_d = ST_SINC_SETUP;
			ST_SINC_SETUP: begin
				if (xs != '0) begin
					state_d = ST_SIN_ARG;
				end else if (sel_q) begin
					state_d = ST_MIX_MUL;
				end
			end
			ST_SIN_ARG:    if (op_done) state_d = ST_SIN_SQ1;
			ST_SIN_SQ1:    if (op_done) state_d = ST_SIN_SQ2;
			ST_SIN_SQ2:    if (op_done) state_d = ST_SIN_DIV;
			ST_SIN_DIV:    if (op_done) state_d = (kk_q == SIN_TERMS) ? ST_DEN_MUL : ST_SIN_SQ1;
			ST_DEN_MUL:    if (op_done) state_d = ST_SINC_DIV;
			ST_SINC_DIV:   if (op_done) state_d = sel_q ? ST_MIX_MUL : ST_SINC_SETUP;
			ST_MIX_MUL:    if (op_done) state_d = ST_FINISH;
			ST_FINISH:     if (out_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// Outputs: handshake, unit starts and operand selection
	always_comb begin
		pitch_stall = (state_q != ST_IDLE);
		mul_start   = is_mul && !issued_q;
		div_start   = is_div && !issued_q;
		mul_a = '0;
		mul_b = '0;
		div_n = '0;
		div_d = '0;
		unique case (state_q)
			ST_NOTE_DIV: begin
				div_n = ND'(m_wide[16:0]);
				div_d = DV'(SEMI_DIV);
			end
			ST_Y_MUL: begin
				mul_a = MA'(r_q);
				mul_b = MB'(LN2_3072);
			end
			ST_EXP_MUL: begin
				mul_a = MA'(term_q);
				mul_b = MB'(y_q);
			end
			ST_EXP_DIV: begin
				div_n = ND'(t_q);
				div_d = DV'(i_q);
			end
			ST_RATE_DIV: begin
				div_n = ND'(sr_q) << F;
				div_d = DV'(RATE_DIV);
			end
			ST_HALF_MUL: begin
				mul_a = MA'(a_q);
				mul_b = MB'(esum_q[31:6]);
			end
			ST_PW_MUL: begin
				mul_a = MA'(per);
				mul_b = MB'(pw_q);
			end
			ST_MOD_PULSE: begin
				div_n = ND'({1'b0, phase_q} + {1'b0, off_q});
				div_d = DV'(per);
			end
			ST_MOD_PHASE: begin
				div_n = ND'({1'b0, phase_q} + (33'd1 << F));
				div_d = DV'(per);
			end
			ST_DC_DIV: begin
				div_n = ND'(DC_Q16) << F;
				div_d = DV'(h_q);
			end
			ST_DC_MUL: begin
				mul_a = MA'(dc_q);
				mul_b = MB'(SINC_ONE) - MB'(mix_q);
			end
			ST_LEAK_MUL: begin
				mul_a = MA'(integ_mag);
				mul_b = MB'(LEAK_Q16);
			end
			ST_SIN_ARG: begin
				mul_a = MA'(w30_q);
				mul_b = PI_Q30;
			end
			ST_SIN_SQ1: begin
				mul_a = MA'(term_q);
				mul_b = MB'(sa_q);
			end
			ST_SIN_SQ2: begin
				mul_a = MA'(t_q);
				mul_b = MB'(sa_q);
			end
			ST_SIN_DIV: begin
				div_n = ND'(t_q);
				div_d = DV'(sin_div(kk_q));
			end
			ST_DEN_MUL: begin
				mul_a = MA'(ax_q);
				mul_b = PI_Q30;
			end
			ST_SINC_DIV: begin
				div_n = ND'(s_cl) << F;
				div_d = DV'(den_q);
			end
			ST_MIX_MUL: begin
				mul_a = MA'(smag_q);
				mul_b = MB'(mix_q);
			end
			default: ;
		endcase
	end

	// Control state, configuration and persistent oscillator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
			sr_q     <= SAMPLE_RATE_RST;
			mix_q    <= MIX_RST;
			pw_q     <= PW_RST;
			phase_q  <= '0;
			integ_q  <= '0;
			valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op_done) begin
				issued_q <= 1'b0;
			end else if (mul_start || div_start) begin
				issued_q <= 1'b1;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SAMPLE_RATE:  sr_q  <= cfg_data[17:0];
					REG_WAVEFORM_MIX: mix_q <= cfg_data[15:0];
					REG_PULSE_WIDTH:  pw_q  <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (state_q == ST_MOD_PHASE && op_done) begin
				phase_q <= rem[31:0];
			end
			// Load the finished beat, else drop the delivered one
			if (state_q == ST_FINISH && out_free) begin
				integ_q <= sat_val;
				valid_q <= 1'b1;
			end else if (valid_q && !sample_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Working registers advance as each operation completes
	always_ff @(posedge clk) begin
		if (accept) begin
			note_q <= pitch_note;
		end
		unique case (state_q)
			ST_NOTE_DIV: if (op_done) begin
				k_q <= $signed(quo[4:0] - OCT_BIAS);
				r_q <= rem[11:0];
			end
			ST_Y_MUL: if (op_done) begin
				y_q    <= prod[29:0];
				term_q <= Q30_ONE;
				esum_q <= 32'(Q30_ONE);
				i_q    <= 4'd1;
			end
			ST_EXP_MUL: if (op_done) t_q <= 32'(prod[59:30]);
			ST_EXP_DIV: if (op_done) begin
				term_q <= quo[30:0];
				esum_q <= esum_q + quo[31:0];
				i_q    <= i_q + 4'd1;
			end
			ST_RATE_DIV:  if (op_done) a_q <= quo[F+8:0];
			ST_HALF_MUL:  if (op_done) h_q <= h_new;
			ST_PW_MUL:    if (op_done) off_q <= prod[47:16];
			ST_MOD_PULSE: if (op_done) p2_q <= rem[31:0];
			ST_DC_DIV:    if (op_done) dc_q <= quo[F+14:0];
			ST_DC_MUL: if (op_done) begin
				acc_q <= -p16;
				sel_q <= 1'b0;
			end
			ST_LEAK_MUL: if (op_done) begin
				acc_q <= integ_q[31] ? acc_q - p16 : acc_q + p16;
			end
			ST_SINC_SETUP: begin
				if (xs == '0) begin
					// Pulse center: the sinc is exactly one
					if (!sel_q) begin
						acc_q <= acc_q + AW'($signed({1'b0, SINC_ONE}));
						sel_q <= 1'b1;
					end else begin
						smag_q <= 25'(SINC_ONE);
						neg_q  <= 1'b0;
					end
				end else begin
					ax_q  <= ax_s[31:0];
					neg_q <= u[F];
					w30_q <= w30;
				end
			end
			ST_SIN_ARG: if (op_done) begin
				sa_q   <= prod[60:30];
				term_q <= prod[60:30];
				ssum_q <= $signed({3'b000, prod[60:30]});
				kk_q   <= 3'd1;
			end
			ST_SIN_SQ1: if (op_done) t_q <= prod[61:30];
			ST_SIN_SQ2: if (op_done) t_q <= prod[61:30];
			ST_SIN_DIV: if (op_done) begin
				term_q <= quo[30:0];
				if (kk_q[0]) begin
					ssum_q <= ssum_q - $signed({3'b000, quo[30:0]});
				end else begin
					ssum_q <= ssum_q + $signed({3'b000, quo[30:0]});
				end
				kk_q <= kk_q + 3'd1;
			end
			ST_DEN_MUL: if (op_done) den_q <= den_new;
			ST_SINC_DIV: if (op_done) begin
				if (!sel_q) begin
					acc_q <= neg_q ? acc_q - q_ext : acc_q + q_ext;
					sel_q <= 1'b1;
				end else begin
					smag_q <= 25'(q24);
				end
			end
			ST_MIX_MUL: if (op_done) begin
				acc_q <= neg_q ? acc_q + p16 : acc_q - p16;
			end
			default: ;
		endcase
	end

	assign sample_valid = valid_q;
	assign sample_out   = integ_q;
	assign cfg_ready    = 1'b1;

endmodule
